>>> design/svf_pkg.sv
// ---------------------------------------------------------------------------
// svf_pkg
// Types and constants shared by the state-variable filter cascade.
// ---------------------------------------------------------------------------
package svf_pkg;

	localparam int FRAC_COEF = 27;

	typedef enum logic [2:0] {
		TAP_ALLPASS  = 3'd0,
		TAP_LOWPASS  = 3'd1,
		TAP_BANDPASS = 3'd2,
		TAP_HIGHPASS = 3'd3,
		TAP_NOTCH    = 3'd4
	} tap_t;

	typedef enum logic [0:0] {
		CFG_STAGE_COUNT = 1'b0,
		CFG_OUTPUT_TAP  = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_FB_R,
		ST_FB_G,
		ST_U,
		ST_HP,
		ST_GH,
		ST_GB,
		ST_AP,
		ST_STORE,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -34'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

>>> design/svf_cascade_filter_core.sv
// ---------------------------------------------------------------------------
// svf_cascade_filter_core
// Cascade of zero-delay-feedback state-variable filter stages with one
// shared multiplier, stepped by a small sequencer.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  in        | in  | in_valid/in_stall  | mode, channel, sample_in, stage_index, coef_*
//  out       | out | out_valid/out_stall| sample_out
//  cfg       | in  | cfg_we             | cfg_index, cfg_data
//
//  Each stage steps through LOAD, FB_R, FB_G, U, HP, GH, GB, AP and STORE;
//  the shared multiplier runs six products per stage, one per cycle.
//  Reset clears tables and integrators, sets stage_count_q to 5'd1 and
//  output_tap_q to TAP_ALLPASS. in_stall is high while a sample is in work
//  or its result waits in the output register.
module svf_cascade_filter_core
	import svf_pkg::*;
#(
	parameter int MAX_STAGES = 16,
	parameter int CHANNELS   = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic               channel,
	input  logic signed [23:0] sample_in,
	input  logic [3:0]         stage_index,
	input  logic [30:0]        coef_g,
	input  logic [30:0]        coef_two_r,
	input  logic [30:0]        coef_h,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] sample_out,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data
);

	localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH = MAX_STAGES * CHANNELS;
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [30:0] g_q [MAX_STAGES];
	logic [30:0] r_q [MAX_STAGES];
	logic [30:0] h_q [MAX_STAGES];
	logic signed [31:0] s1_q [DEPTH];
	logic signed [31:0] s2_q [DEPTH];

	logic [4:0] stage_count_q;
	logic [2:0] output_tap_q;
	state_t state_q, state_d;
	logic [SW:0] k_q;
	logic [CW-1:0] ch_q;
	logic [SW:0] stages;
	logic signed [31:0] x_q, s1_v, s2_v, acc_q, hp_q, gh_q, bp_q, gb_q, lp_q;
	logic [30:0] gc, rc, hc;
	logic [IW-1:0] idx;

	// shared multiplier
	logic signed [31:0] m_a;
	logic [30:0] m_c;
	logic signed [63:0] m_p;
	logic signed [31:0] m_y;
	logic signed [35:0] m_sh;

	logic [CW-1:0] ch_in;

	always_comb begin
		if (CHANNELS > 1)
			ch_in = CW'(channel);
		else
			ch_in = '0;
	end

	assign stages = (int'(stage_count_q) > MAX_STAGES) ? (SW+1)'(MAX_STAGES)
		: (SW+1)'(stage_count_q);
	assign idx = IW'(k_q[SW-1:0] * CHANNELS + ch_q);
	assign gc = g_q[k_q[SW-1:0]];
	assign rc = r_q[k_q[SW-1:0]];
	assign hc = h_q[k_q[SW-1:0]];

	always_comb begin
		m_a = acc_q;
		m_c = gc;
		unique case (state_q)
			ST_FB_R: begin m_a = s1_v; m_c = rc; end
			ST_FB_G: begin m_a = s1_v; m_c = gc; end
			ST_HP:   begin m_a = acc_q; m_c = hc; end
			ST_GH:   begin m_a = hp_q; m_c = gc; end
			ST_GB:   begin m_a = bp_q; m_c = gc; end
			ST_AP:   begin m_a = bp_q; m_c = rc; end
			default: begin m_a = acc_q; m_c = gc; end
		endcase
		m_p = m_a * $signed({33'd0, m_c});
		m_p = m_p + 64'sd67108864;
		m_sh = m_p[62:27];
		m_y = sat32(m_sh[33:0]);
		if (m_sh > 36'sd2147483647)
			m_y = 32'sh7fffffff;
		else if (m_sh < -36'sd2147483648)
			m_y = 32'sh80000000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= '0;
			s2_v <= '0;
		end else if (state_q == ST_LOAD) begin
			s1_v <= s1_q[idx];
			s2_v <= s2_q[idx];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid && !in_stall && !mode)
				state_d = (stages == '0) ? ST_OUT : ST_LOAD;
			ST_LOAD:  state_d = ST_FB_R;
			ST_FB_R:  state_d = ST_FB_G;
			ST_FB_G:  state_d = ST_U;
			ST_U:     state_d = ST_HP;
			ST_HP:    state_d = ST_GH;
			ST_GH:    state_d = ST_GB;
			ST_GB:    state_d = ST_AP;
			ST_AP:    state_d = ST_STORE;
			ST_STORE: state_d = (k_q + 1'b1 >= stages) ? ST_OUT : ST_LOAD;
			ST_OUT:   if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	always_comb begin
		if (x_q > 32'sd8388607)
			sample_out = 24'sh7fffff;
		else if (x_q < -32'sd8388608)
			sample_out = 24'sh800000;
		else
			sample_out = x_q[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_count_q <= 5'd1;
			output_tap_q <= TAP_ALLPASS;
			k_q <= '0;
			ch_q <= '0;
			x_q <= '0;
			acc_q <= '0;
			hp_q <= '0;
			gh_q <= '0;
			bp_q <= '0;
			gb_q <= '0;
			lp_q <= '0;
			for (int i = 0; i < MAX_STAGES; i++) begin
				g_q[i] <= '0;
				r_q[i] <= '0;
				h_q[i] <= '0;
			end
			for (int i = 0; i < DEPTH; i++) begin
				s1_q[i] <= '0;
				s2_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_STAGE_COUNT: stage_count_q <= cfg_data;
					CFG_OUTPUT_TAP:  output_tap_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						if (mode) begin
							if ({28'd0, stage_index} < MAX_STAGES) begin
								g_q[SW'(stage_index)] <= coef_g;
								r_q[SW'(stage_index)] <= coef_two_r;
								h_q[SW'(stage_index)] <= coef_h;
							end
						end else begin
							x_q <= 32'(sample_in);
							ch_q <= ch_in;
							k_q <= '0;
						end
					end
				end
				ST_FB_R: acc_q <= m_y;
				ST_FB_G: acc_q <= sat32(34'(x_q) - 34'(acc_q) - 34'(m_y) - 34'(s2_v));
				ST_U: acc_q <= acc_q;
				ST_HP: hp_q <= m_y;
				ST_GH: begin
					gh_q <= m_y;
					bp_q <= sat32(34'(m_y) + 34'(s1_v));
				end
				ST_GB: begin
					gb_q <= m_y;
					lp_q <= sat32(34'(m_y) + 34'(s2_v));
				end
				ST_AP: begin
					s1_q[idx] <= sat32(34'(gh_q) + 34'(bp_q));
					s2_q[idx] <= sat32(34'(gb_q) + 34'(lp_q));
					unique case (output_tap_q)
						TAP_ALLPASS: x_q <= sat32(34'(lp_q) + 34'(hp_q) - 34'(m_y));
						TAP_LOWPASS: x_q <= lp_q;
						TAP_BANDPASS: x_q <= bp_q;
						TAP_HIGHPASS: x_q <= hp_q;
						default: x_q <= sat32(34'(lp_q) + 34'(hp_q));
					endcase
				end
				ST_STORE: k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Result only after a sample was taken in.
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_STORE || $past(state_q) == ST_IDLE))
		else $error("result without sample");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("result lost");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("accept during result");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the state-variable filter cascade. Coefficient
// writes and samples are driven over the valid/stall input channel; a local
// fixed-point model of every stage predicts each filtered sample, which is
// compared with the output channel in arrival order.
// ---------------------------------------------------------------------------
module tb;
	import svf_pkg::*;

	localparam int NSTG = 16;
	localparam int NCH = 2;
	localparam int WD_LIMIT = 20000;

	logic clk, arst_n;
	logic in_valid, in_stall, mode, channel;
	logic signed [23:0] sample_in, sample_out;
	logic [3:0] stage_index;
	logic [30:0] coef_g, coef_two_r, coef_h;
	logic out_valid, out_stall;
	logic cfg_we, cfg_index;
	logic [4:0] cfg_data;

	svf_cascade_filter_core uut (.*);

	logic [30:0] gain_q[NSTG], damp_q[NSTG], norm_q[NSTG];
	logic signed [31:0] integ1[NSTG*NCH], integ2[NSTG*NCH];
	logic [4:0] n_stages;
	logic [2:0] tap_sel;
	logic signed [23:0] filtered_q[$];
	int errors = 0;
	int idle_pct = 7;
	bit rx_hold = 0;
	int quiet = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [31:0] clip32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic [30:0] c);
		logic signed [63:0] p;
		p = a * $signed({33'd0, c}) + 64'sd67108864;
		return clip32(p >>> 27);
	endfunction

	function automatic logic signed [23:0] filter_sample(int ch, logic signed [23:0] smp);
		logic signed [31:0] x, s1, s2, u, hp, gh, bp, gb, lp;
		logic signed [63:0] fb;
		int nst, idx;
		x = smp;
		nst = n_stages > NSTG ? NSTG : n_stages;
		for (int k = 0; k < nst; k++) begin
			idx = k * NCH + ch;
			s1 = integ1[idx];
			s2 = integ2[idx];
			fb = 64'(qmul(s1, damp_q[k])) + 64'(qmul(s1, gain_q[k]));
			u = clip32(64'(x) - fb - 64'(s2));
			hp = qmul(u, norm_q[k]);
			gh = qmul(hp, gain_q[k]);
			bp = clip32(64'(gh) + 64'(s1));
			gb = qmul(bp, gain_q[k]);
			lp = clip32(64'(gb) + 64'(s2));
			integ1[idx] = clip32(64'(gh) + 64'(bp));
			integ2[idx] = clip32(64'(gb) + 64'(lp));
			case (tap_sel)
				TAP_ALLPASS: x = clip32(64'(lp) + 64'(hp) - 64'(qmul(bp, damp_q[k])));
				TAP_LOWPASS: x = lp;
				TAP_BANDPASS: x = bp;
				TAP_HIGHPASS: x = hp;
				default: x = clip32(64'(lp) + 64'(hp));
			endcase
		end
		if (x > 32'sd8388607) return 24'sh7fffff;
		if (x < -32'sd8388608) return 24'sh800000;
		return x[23:0];
	endfunction

	task automatic send_item(bit m, bit ch, logic [23:0] smp, logic [3:0] si,
			logic [30:0] g, logic [30:0] r, logic [30:0] h);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; mode <= m; channel <= ch; sample_in <= smp;
		stage_index <= si; coef_g <= g; coef_two_r <= r; coef_h <= h;
		do @(posedge clk); while (in_stall);
		if (m) begin
			gain_q[si] = g; damp_q[si] = r; norm_q[si] = h;
		end else
			filtered_q.push_back(filter_sample(ch, smp));
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [4:0] val);
		in_valid <= 0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (160) @(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_STAGE_COUNT) n_stages = val; else tap_sel = val[2:0];
	endtask

	// a stable-ish stage: g up to 2, 2R up to 2, h between 1/8 and 1 (wild: any 31-bit values)
	task automatic load_stage(int s, bit wild);
		logic [30:0] g, r, h;
		if (wild) begin
			g = 31'($urandom); r = 31'($urandom); h = 31'($urandom);
		end else begin
			g = 31'($urandom_range(32'h1000_0000, 32'h0010_0000));
			r = 31'($urandom_range(32'h1000_0000, 32'h0080_0000));
			h = 31'($urandom_range(32'h0800_0000, 32'h0100_0000));
		end
		send_item(1, 1'($urandom), 24'($urandom), s[3:0], g, r, h);
	endtask

	task automatic send_sample(logic [23:0] smp);
		send_item(0, 1'($urandom), smp, 4'($urandom), 31'($urandom), 31'($urandom),
			31'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= rx_hold || ($urandom_range(99) < idle_pct);
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					$display("%0t: unexpected sample_out %h", $time, sample_out);
					errors++;
				end else begin
					if (filtered_q[0] !== sample_out) begin
						$display("%0t: sample_out expected %h actual %h", $time,
							filtered_q[0], sample_out);
						errors++;
					end
					void'(filtered_q.pop_front());
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet > WD_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	task automatic test_passthrough();
		write_reg(CFG_STAGE_COUNT, 0);
		send_sample(24'h7fffff); send_sample(24'h800000); send_sample(24'h000001);
		send_sample(24'hffffff);
	endtask

	task automatic test_unwritten();
		write_reg(CFG_STAGE_COUNT, 1);
		send_sample(24'h400000); send_sample(24'h800000);
	endtask

	task automatic test_taps();
		for (int s = 0; s < NSTG; s++) load_stage(s, 0);
		send_item(1, 0, 0, 4'hf, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
		write_reg(CFG_STAGE_COUNT, 2);
		for (int t = 0; t < 8; t++) begin
			write_reg(CFG_OUTPUT_TAP, 5'(t));
			send_sample(24'h7fffff); send_sample(24'h800000);
		end
		write_reg(CFG_STAGE_COUNT, 31);
		send_sample(24'h123456);
		for (int s = 0; s < NSTG; s++) load_stage(s, 0);
	endtask

	task automatic test_random();
		for (int n = 0; n < 1850; n++) begin
			if (n % 200 == 0) begin
				write_reg(CFG_STAGE_COUNT,
					5'($urandom_range(3) == 0 ? $urandom : $urandom_range(4)));
				write_reg(CFG_OUTPUT_TAP, 5'($urandom));
			end
			idle_pct = (n >= 600 && n < 900) ? 0 : 7;
			if ($urandom_range(19) == 0) load_stage($urandom_range(15), $urandom_range(3) == 0);
			else if ($urandom_range(3) == 0)
				send_sample($urandom_range(1) ? 24'h7fffff : 24'h800000);
			else send_sample(24'($urandom));
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1;
				repeat (3000) @(posedge clk);
				rx_hold = 0;
			end
			for (int n = 0; n < 20; n++) send_sample(24'($urandom));
		join
	endtask

	initial begin
		arst_n = 0; in_valid = 0; out_stall = 0; mode = 0; channel = 0;
		sample_in = 0; stage_index = 0; coef_g = 0; coef_two_r = 0; coef_h = 0;
		cfg_we = 0; cfg_index = CFG_STAGE_COUNT; cfg_data = 0;
		n_stages = 1; tap_sel = TAP_ALLPASS;
		for (int i = 0; i < NSTG; i++) begin
			gain_q[i] = 0; damp_q[i] = 0; norm_q[i] = 0;
		end
		for (int i = 0; i < NSTG * NCH; i++) begin
			integ1[i] = 0; integ2[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_passthrough();
		test_unwritten();
		test_taps();
		test_backpressure();
		test_random();
		in_valid <= 0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
